[rtl/core/rpmc_pkg.sv]
package rpmc_pkg;

    // grid and field sizes
    localparam int MAX_SIDE   = 64;
    localparam int SIDE_W     = $clog2(MAX_SIDE);
    localparam int CELL_COUNT = MAX_SIDE * MAX_SIDE;
    localparam int CELL_AW    = $clog2(CELL_COUNT);
    localparam int CNT_W      = CELL_AW + 1;
    localparam int SIZE_W     = 7;
    localparam int RAND_W     = 31;
    localparam int MAP_W      = 8;
    localparam int KIND_W     = 2;
    localparam int ND_W       = 3;
    localparam int DIRS_W     = 8;
    localparam int ENTRY_W    = 2 * SIDE_W + ND_W + DIRS_W;

    // cell status codes
    localparam logic [1:0] ST_UNVISITED = 2'd0;
    localparam logic [1:0] ST_FRONTIER  = 2'd1;
    localparam logic [1:0] ST_CARVED    = 2'd2;

    // directions
    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_S = 2'd1;
    localparam logic [1:0] DIR_E = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    // result kinds, also used as emit selector
    localparam logic [1:0] KIND_CELL = 2'd0;
    localparam logic [1:0] KIND_WALL = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    // divider operand selectors
    localparam logic [1:0] SEL_COL  = 2'd0;
    localparam logic [1:0] SEL_ROW  = 2'd1;
    localparam logic [1:0] SEL_PICK = 2'd2;
    localparam logic [1:0] SEL_DIR  = 2'd3;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // datapath operations
    typedef logic [4:0] op_t;
    localparam op_t OP_NOP         = 5'd0;
    localparam op_t OP_CAPTURE     = 5'd1;
    localparam op_t OP_CLR_STEP    = 5'd2;
    localparam op_t OP_DIV_START   = 5'd3;
    localparam op_t OP_DIV_STEP    = 5'd4;
    localparam op_t OP_DIV_TAKE    = 5'd5;
    localparam op_t OP_START_CELL  = 5'd6;
    localparam op_t OP_READ_PICK   = 5'd7;
    localparam op_t OP_TAKE_CHOSEN = 5'd8;
    localparam op_t OP_GROW_CELL   = 5'd9;
    localparam op_t OP_NB_READ     = 5'd10;
    localparam op_t OP_NB_ADD      = 5'd11;
    localparam op_t OP_NB_NEXT     = 5'd12;
    localparam op_t OP_SCAN_INIT   = 5'd13;
    localparam op_t OP_SCAN_READ   = 5'd14;
    localparam op_t OP_SCAN_NEXT   = 5'd15;
    localparam op_t OP_SCAN_UPD    = 5'd16;
    localparam op_t OP_SHIFT_INIT  = 5'd17;
    localparam op_t OP_SHIFT_READ  = 5'd18;
    localparam op_t OP_SHIFT_WRITE = 5'd19;
    localparam op_t OP_DEC_COUNT   = 5'd20;
    localparam op_t OP_EMIT        = 5'd21;

    typedef struct packed {
        op_t        op;
        logic [1:0] sel;
    } cmd_t;

    typedef struct packed {
        logic       div_done;
        logic       nb_valid;
        logic [1:0] nb_stat;
        logic       scan_end;
        logic       scan_match;
        logic       shift_end;
        logic       fcount_zero;
        logic       out_free;
        logic       d_last;
        logic       clr_last;
    } status_t;

    function automatic logic [SIZE_W-1:0] eff_side(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (v > SIZE_W'(MAX_SIDE))
        begin
            r = SIZE_W'(MAX_SIDE);
        end
        return r;
    endfunction

endpackage

[rtl/core/rpmc_ctrl.sv]
module rpmc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               action,
    output logic               req_stall,
    input  rpmc_pkg::status_t  status,
    output rpmc_pkg::cmd_t     cmd
);
    import rpmc_pkg::*;

    localparam logic [4:0] S_IDLE       = 5'd0;
    localparam logic [4:0] S_CLR        = 5'd1;
    localparam logic [4:0] S_DIV_LOAD   = 5'd2;
    localparam logic [4:0] S_DIV        = 5'd3;
    localparam logic [4:0] S_START      = 5'd4;
    localparam logic [4:0] S_PICK_RD    = 5'd5;
    localparam logic [4:0] S_PICK_TAKE  = 5'd6;
    localparam logic [4:0] S_GROW       = 5'd7;
    localparam logic [4:0] S_NB         = 5'd8;
    localparam logic [4:0] S_NB_CHK     = 5'd9;
    localparam logic [4:0] S_SCAN_RD    = 5'd10;
    localparam logic [4:0] S_SCAN_CMP   = 5'd11;
    localparam logic [4:0] S_NB_ADV     = 5'd12;
    localparam logic [4:0] S_SHIFT_INIT = 5'd13;
    localparam logic [4:0] S_SH_RD      = 5'd14;
    localparam logic [4:0] S_SH_WR      = 5'd15;
    localparam logic [4:0] S_EMIT_WALL  = 5'd16;
    localparam logic [4:0] S_EMIT_CELL  = 5'd17;
    localparam logic [4:0] S_EMPTY      = 5'd18;

    logic [4:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       grow_reg, grow_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        grow_next  = grow_reg;
        cmd.op     = OP_NOP;
        cmd.sel    = 2'd0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op    = OP_CAPTURE;
                    grow_next = action;
                    if (!action)
                    begin
                        state_next = S_CLR;
                    end
                    else if (status.fcount_zero)
                    begin
                        state_next = S_EMPTY;
                    end
                    else
                    begin
                        phase_next = SEL_PICK;
                        state_next = S_DIV_LOAD;
                    end
                end
            end
            S_CLR:
            begin
                cmd.op = OP_CLR_STEP;
                if (status.clr_last)
                begin
                    phase_next = SEL_COL;
                    state_next = S_DIV_LOAD;
                end
            end
            S_DIV_LOAD:
            begin
                cmd.op     = OP_DIV_START;
                cmd.sel    = phase_reg;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!status.div_done)
                begin
                    cmd.op = OP_DIV_STEP;
                end
                else
                begin
                    cmd.op  = OP_DIV_TAKE;
                    cmd.sel = phase_reg;
                    case (phase_reg)
                        SEL_COL:
                        begin
                            phase_next = SEL_ROW;
                            state_next = S_DIV_LOAD;
                        end
                        SEL_ROW:  state_next = S_START;
                        SEL_PICK: state_next = S_PICK_RD;
                        default:  state_next = S_GROW;
                    endcase
                end
            end
            S_START:
            begin
                cmd.op     = OP_START_CELL;
                state_next = S_NB;
            end
            S_PICK_RD:
            begin
                cmd.op     = OP_READ_PICK;
                state_next = S_PICK_TAKE;
            end
            S_PICK_TAKE:
            begin
                cmd.op     = OP_TAKE_CHOSEN;
                phase_next = SEL_DIR;
                state_next = S_DIV_LOAD;
            end
            S_GROW:
            begin
                cmd.op     = OP_GROW_CELL;
                state_next = S_NB;
            end
            S_NB:
            begin
                if (status.nb_valid)
                begin
                    cmd.op     = OP_NB_READ;
                    state_next = S_NB_CHK;
                end
                else
                begin
                    state_next = S_NB_ADV;
                end
            end
            S_NB_CHK:
            begin
                if (status.nb_stat == ST_UNVISITED)
                begin
                    cmd.op     = OP_NB_ADD;
                    state_next = S_NB_ADV;
                end
                else if (status.nb_stat == ST_FRONTIER)
                begin
                    cmd.op     = OP_SCAN_INIT;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_NB_ADV;
                end
            end
            S_SCAN_RD:
            begin
                if (status.scan_end)
                begin
                    state_next = S_NB_ADV;
                end
                else
                begin
                    cmd.op     = OP_SCAN_READ;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (status.scan_match)
                begin
                    cmd.op     = OP_SCAN_UPD;
                    state_next = S_NB_ADV;
                end
                else
                begin
                    cmd.op     = OP_SCAN_NEXT;
                    state_next = S_SCAN_RD;
                end
            end
            S_NB_ADV:
            begin
                cmd.op = OP_NB_NEXT;
                if (!status.d_last)
                begin
                    state_next = S_NB;
                end
                else if (grow_reg)
                begin
                    state_next = S_SHIFT_INIT;
                end
                else
                begin
                    state_next = S_EMIT_CELL;
                end
            end
            S_SHIFT_INIT:
            begin
                cmd.op     = OP_SHIFT_INIT;
                state_next = S_SH_RD;
            end
            S_SH_RD:
            begin
                if (status.shift_end)
                begin
                    cmd.op     = OP_DEC_COUNT;
                    state_next = S_EMIT_WALL;
                end
                else
                begin
                    cmd.op     = OP_SHIFT_READ;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.op     = OP_SHIFT_WRITE;
                state_next = S_SH_RD;
            end
            S_EMIT_WALL:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    cmd.sel    = KIND_WALL;
                    state_next = S_EMIT_CELL;
                end
            end
            S_EMIT_CELL:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    cmd.sel    = KIND_CELL;
                    state_next = S_IDLE;
                end
            end
            S_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    cmd.sel    = KIND_NONE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= SEL_COL;
            grow_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            grow_reg  <= grow_next;
        end
    end

endmodule

[rtl/core/rpmc_dpath.sv]
module rpmc_dpath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic                                   cfg_index,
    input  logic [rpmc_pkg::SIZE_W-1:0]            cfg_data,
    input  logic [rpmc_pkg::RAND_W-1:0]            random_first,
    input  logic [rpmc_pkg::RAND_W-1:0]            random_second,
    input  logic                                   rsp_stall,
    output logic                                   rsp_valid,
    output logic [rpmc_pkg::MAP_W-1:0]             map_row,
    output logic [rpmc_pkg::MAP_W-1:0]             map_col,
    output logic [rpmc_pkg::KIND_W-1:0]            carve_kind,
    output logic [rpmc_pkg::CNT_W-1:0]             frontier_left,
    output logic                                   maze_done,
    output logic                                   last_of_step,
    input  rpmc_pkg::cmd_t                         cmd,
    output rpmc_pkg::status_t                      status
);
    import rpmc_pkg::*;

    localparam logic [4:0] DIV_STEPS = 5'(RAND_W);

    // memories
    logic [1:0]         cell_mem [CELL_COUNT];
    logic [ENTRY_W-1:0] front_mem [CELL_COUNT];

    logic [SIZE_W-1:0]  width_reg, height_reg;
    logic [RAND_W-1:0]  r1_reg, r2_reg;
    logic [CELL_AW-1:0] clr_reg;
    logic [RAND_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]   rem_reg, dvs_reg;
    logic [4:0]         dcnt_reg;
    logic [SIDE_W-1:0]  row_reg, col_reg, cur_row_reg, cur_col_reg;
    logic [CELL_AW-1:0] pick_reg;
    logic [1:0]         dirk_reg, d_idx_reg;
    logic [ENTRY_W-1:0] chosen_reg, front_rd_reg;
    logic [1:0]         cell_rd_reg;
    logic [CNT_W-1:0]   fcount_reg, scan_reg;
    logic [MAP_W-1:0]   wall_row_reg, wall_col_reg;
    logic               out_valid_reg;
    logic [MAP_W-1:0]   map_row_reg, map_col_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [CNT_W-1:0]   left_reg;
    logic               done_reg, last_reg;

    logic [SIZE_W-1:0]  effw, effh, row_ext, col_ext, nb_row, nb_col;
    logic               nb_edge_ok;
    logic [CELL_AW-1:0] nb_idx, chosen_idx;
    logic [CNT_W:0]     trial;
    logic [CNT_W-1:0]   rem_step;
    logic [SIDE_W-1:0]  rd_row, rd_col, ch_row, ch_col;
    logic [ND_W-1:0]    rd_nd, ch_nd;
    logic [DIRS_W-1:0]  rd_dirs, upd_dirs;
    logic [1:0]         grow_dir;
    logic [MAP_W-1:0]   ch_map_row, ch_map_col;
    logic [CNT_W-1:0]   scan_inc;

    logic               cell_we;
    logic [CELL_AW-1:0] cell_waddr;
    logic [1:0]         cell_wdata;
    logic               front_we, front_re;
    logic [CELL_AW-1:0] front_waddr, front_raddr;
    logic [ENTRY_W-1:0] front_wdata;

    assign effw = eff_side(width_reg);
    assign effh = eff_side(height_reg);

    assign rd_row  = front_rd_reg[ENTRY_W-1 -: SIDE_W];
    assign rd_col  = front_rd_reg[ENTRY_W-SIDE_W-1 -: SIDE_W];
    assign rd_nd   = front_rd_reg[DIRS_W +: ND_W];
    assign rd_dirs = front_rd_reg[DIRS_W-1:0];
    assign ch_row  = chosen_reg[ENTRY_W-1 -: SIDE_W];
    assign ch_col  = chosen_reg[ENTRY_W-SIDE_W-1 -: SIDE_W];
    assign ch_nd   = chosen_reg[DIRS_W +: ND_W];
    assign grow_dir   = chosen_reg[{dirk_reg, 1'b0} +: 2];
    assign chosen_idx = {ch_row, ch_col};
    assign ch_map_row = {1'b0, ch_row, 1'b1};
    assign ch_map_col = {1'b0, ch_col, 1'b1};
    assign scan_inc   = scan_reg + CNT_W'(1);

    // neighbour of the current cell in direction d_idx
    always_comb
    begin
        row_ext    = {1'b0, cur_row_reg};
        col_ext    = {1'b0, cur_col_reg};
        nb_row     = row_ext;
        nb_col     = col_ext;
        nb_edge_ok = 1'b1;
        case (d_idx_reg)
            DIR_N:
            begin
                nb_edge_ok = (cur_row_reg != '0);
                nb_row     = row_ext - SIZE_W'(1);
            end
            DIR_S:   nb_row = row_ext + SIZE_W'(1);
            DIR_E:   nb_col = col_ext + SIZE_W'(1);
            default:
            begin
                nb_edge_ok = (cur_col_reg != '0);
                nb_col     = col_ext - SIZE_W'(1);
            end
        endcase
    end

    assign nb_idx = {nb_row[SIDE_W-1:0], nb_col[SIDE_W-1:0]};

    // one restoring division step
    always_comb
    begin
        trial = {rem_reg, dvd_reg[RAND_W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_step = CNT_W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_step = trial[CNT_W-1:0];
        end
    end

    // append the discoverer direction to a found entry
    always_comb
    begin
        upd_dirs = rd_dirs;
        upd_dirs[{rd_nd[1:0], 1'b0} +: 2] = d_idx_reg;
    end

    always_comb
    begin
        cell_we     = 1'b0;
        cell_waddr  = nb_idx;
        cell_wdata  = ST_UNVISITED;
        front_we    = 1'b0;
        front_waddr = scan_reg[CELL_AW-1:0];
        front_wdata = front_rd_reg;
        front_re    = 1'b0;
        front_raddr = scan_reg[CELL_AW-1:0];
        case (cmd.op)
            OP_CLR_STEP:
            begin
                cell_we    = 1'b1;
                cell_waddr = clr_reg;
            end
            OP_START_CELL:
            begin
                cell_we    = 1'b1;
                cell_waddr = {row_reg, col_reg};
                cell_wdata = ST_CARVED;
            end
            OP_GROW_CELL:
            begin
                cell_we    = 1'b1;
                cell_waddr = chosen_idx;
                cell_wdata = ST_CARVED;
            end
            OP_NB_ADD:
            begin
                cell_we     = (fcount_reg < CNT_W'(CELL_COUNT));
                cell_wdata  = ST_FRONTIER;
                front_we    = cell_we;
                front_waddr = fcount_reg[CELL_AW-1:0];
                front_wdata = {nb_row[SIDE_W-1:0], nb_col[SIDE_W-1:0], ND_W'(1),
                               {(DIRS_W-2){1'b0}}, d_idx_reg};
            end
            OP_SCAN_UPD:
            begin
                front_we    = (rd_nd < ND_W'(4));
                front_wdata = {rd_row, rd_col, rd_nd + ND_W'(1), upd_dirs};
            end
            OP_READ_PICK:
            begin
                front_re    = 1'b1;
                front_raddr = pick_reg;
            end
            OP_SCAN_READ:
            begin
                front_re = 1'b1;
            end
            OP_SHIFT_READ:
            begin
                front_re    = 1'b1;
                front_raddr = scan_inc[CELL_AW-1:0];
            end
            OP_SHIFT_WRITE:
            begin
                front_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_waddr] <= cell_wdata;
        end
        if (cmd.op == OP_NB_READ)
        begin
            cell_rd_reg <= cell_mem[nb_idx];
        end
        if (front_we)
        begin
            front_mem[front_waddr] <= front_wdata;
        end
        if (front_re)
        begin
            front_rd_reg <= front_mem[front_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= SIZE_W'(8);
            height_reg    <= SIZE_W'(8);
            r1_reg        <= '0;
            r2_reg        <= '0;
            clr_reg       <= '0;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            dvs_reg       <= CNT_W'(1);
            dcnt_reg      <= DIV_STEPS;
            row_reg       <= '0;
            col_reg       <= '0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            pick_reg      <= '0;
            dirk_reg      <= '0;
            d_idx_reg     <= '0;
            chosen_reg    <= '0;
            fcount_reg    <= '0;
            scan_reg      <= '0;
            wall_row_reg  <= '0;
            wall_col_reg  <= '0;
            out_valid_reg <= 1'b0;
            map_row_reg   <= '0;
            map_col_reg   <= '0;
            kind_reg      <= '0;
            left_reg      <= '0;
            done_reg      <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_WIDTH)
                begin
                    width_reg <= cfg_data;
                end
                else
                begin
                    height_reg <= cfg_data;
                end
            end
            // result taken and no new one loaded this cycle
            if (out_valid_reg && !rsp_stall && cmd.op != OP_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_CAPTURE:
                begin
                    r1_reg  <= random_first;
                    r2_reg  <= random_second;
                    clr_reg <= '0;
                end
                OP_CLR_STEP:
                begin
                    clr_reg <= clr_reg + CELL_AW'(1);
                end
                OP_DIV_START:
                begin
                    rem_reg  <= '0;
                    dcnt_reg <= '0;
                    if (cmd.sel == SEL_COL || cmd.sel == SEL_PICK)
                    begin
                        dvd_reg <= r1_reg;
                    end
                    else
                    begin
                        dvd_reg <= r2_reg;
                    end
                    case (cmd.sel)
                        SEL_COL:  dvs_reg <= CNT_W'(effw);
                        SEL_ROW:  dvs_reg <= CNT_W'(effh);
                        SEL_PICK: dvs_reg <= fcount_reg;
                        default:  dvs_reg <= (ch_nd == '0) ? CNT_W'(1) : CNT_W'(ch_nd);
                    endcase
                end
                OP_DIV_STEP:
                begin
                    rem_reg  <= rem_step;
                    dvd_reg  <= {dvd_reg[RAND_W-2:0], 1'b0};
                    dcnt_reg <= dcnt_reg + 5'd1;
                end
                OP_DIV_TAKE:
                begin
                    case (cmd.sel)
                        SEL_COL:  col_reg  <= rem_reg[SIDE_W-1:0];
                        SEL_ROW:  row_reg  <= rem_reg[SIDE_W-1:0];
                        SEL_PICK: pick_reg <= rem_reg[CELL_AW-1:0];
                        default:  dirk_reg <= rem_reg[1:0];
                    endcase
                end
                OP_START_CELL:
                begin
                    cur_row_reg <= row_reg;
                    cur_col_reg <= col_reg;
                    fcount_reg  <= '0;
                    d_idx_reg   <= DIR_N;
                end
                OP_TAKE_CHOSEN:
                begin
                    chosen_reg <= front_rd_reg;
                end
                OP_GROW_CELL:
                begin
                    cur_row_reg  <= ch_row;
                    cur_col_reg  <= ch_col;
                    d_idx_reg    <= DIR_N;
                    case (grow_dir)
                        DIR_N:
                        begin
                            wall_row_reg <= ch_map_row + MAP_W'(1);
                            wall_col_reg <= ch_map_col;
                        end
                        DIR_S:
                        begin
                            wall_row_reg <= ch_map_row - MAP_W'(1);
                            wall_col_reg <= ch_map_col;
                        end
                        DIR_E:
                        begin
                            wall_row_reg <= ch_map_row;
                            wall_col_reg <= ch_map_col - MAP_W'(1);
                        end
                        default:
                        begin
                            wall_row_reg <= ch_map_row;
                            wall_col_reg <= ch_map_col + MAP_W'(1);
                        end
                    endcase
                end
                OP_NB_ADD:
                begin
                    if (fcount_reg < CNT_W'(CELL_COUNT))
                    begin
                        fcount_reg <= fcount_reg + CNT_W'(1);
                    end
                end
                OP_NB_NEXT:
                begin
                    d_idx_reg <= d_idx_reg + 2'd1;
                end
                OP_SCAN_INIT:
                begin
                    scan_reg <= '0;
                end
                OP_SCAN_NEXT:
                begin
                    scan_reg <= scan_inc;
                end
                OP_SHIFT_INIT:
                begin
                    scan_reg <= CNT_W'(pick_reg);
                end
                OP_SHIFT_WRITE:
                begin
                    scan_reg <= scan_inc;
                end
                OP_DEC_COUNT:
                begin
                    fcount_reg <= fcount_reg - CNT_W'(1);
                end
                OP_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    kind_reg      <= cmd.sel;
                    left_reg      <= fcount_reg;
                    done_reg      <= (fcount_reg == '0);
                    last_reg      <= (cmd.sel != KIND_WALL);
                    case (cmd.sel)
                        KIND_WALL:
                        begin
                            map_row_reg <= wall_row_reg;
                            map_col_reg <= wall_col_reg;
                        end
                        KIND_CELL:
                        begin
                            map_row_reg <= {1'b0, cur_row_reg, 1'b1};
                            map_col_reg <= {1'b0, cur_col_reg, 1'b1};
                        end
                        default:
                        begin
                            map_row_reg <= '0;
                            map_col_reg <= '0;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    assign status.div_done    = (dcnt_reg == DIV_STEPS);
    assign status.nb_valid    = nb_edge_ok && (nb_row < effh) && (nb_col < effw);
    assign status.nb_stat     = cell_rd_reg;
    assign status.scan_end    = (scan_reg >= fcount_reg);
    assign status.scan_match  = (rd_row == nb_row[SIDE_W-1:0]) &&
                                (rd_col == nb_col[SIDE_W-1:0]);
    assign status.shift_end   = (scan_inc >= fcount_reg);
    assign status.fcount_zero = (fcount_reg == '0);
    assign status.out_free    = !out_valid_reg || !rsp_stall;
    assign status.d_last      = (d_idx_reg == DIR_W);
    assign status.clr_last    = (clr_reg == CELL_AW'(CELL_COUNT - 1));

    assign rsp_valid     = out_valid_reg;
    assign map_row       = map_row_reg;
    assign map_col       = map_col_reg;
    assign carve_kind    = kind_reg;
    assign frontier_left = left_reg;
    assign maze_done     = done_reg;
    assign last_of_step  = last_reg;

    a_fcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcount_reg <= CNT_W'(CELL_COUNT))
        else $error("frontier count above capacity");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (dcnt_reg == DIV_STEPS) |-> (rem_reg < dvs_reg))
        else $error("remainder not below divisor");

    a_done_left: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (done_reg == (left_reg == '0)))
        else $error("maze_done disagrees with frontier_left");

    a_wall_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_WALL) |-> !last_reg)
        else $error("wall result marked last");

endmodule

[rtl/core/random_prim_maze_carver_unit.sv]
// start item: cell store clear, two modulo passes, then up to
//   4 neighbour checks (each a scan of the frontier, a read and a compare per entry)
// grow item: modulo passes and a frontier fetch, neighbour scans as above, then an ordered
//   removal that reads and rewrites each entry behind the chosen one; one item at a time
// the modulo unit retires one quotient bit per cycle; frontier memory has one port
// reset: sizes 8 x 8, frontier empty, output idle; cell store cleared by each start
module random_prim_maze_carver_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [rpmc_pkg::SIZE_W-1:0]         cfg_data,
    // request channel
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic                                action,
    input  logic [rpmc_pkg::RAND_W-1:0]         random_first,
    input  logic [rpmc_pkg::RAND_W-1:0]         random_second,
    // result channel
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [rpmc_pkg::MAP_W-1:0]          map_row,
    output logic [rpmc_pkg::MAP_W-1:0]          map_col,
    output logic [rpmc_pkg::KIND_W-1:0]         carve_kind,
    output logic [rpmc_pkg::CNT_W-1:0]          frontier_left,
    output logic                                maze_done,
    output logic                                last_of_step
);
    import rpmc_pkg::*;

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t status;

    // sequencer: one transaction in flight, stalls requests until done
    rpmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .action    (action),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: cell store, frontier memory, modulo unit, result register
    rpmc_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .random_first  (random_first),
        .random_second (random_second),
        .rsp_stall     (rsp_stall),
        .rsp_valid     (rsp_valid),
        .map_row       (map_row),
        .map_col       (map_col),
        .carve_kind    (carve_kind),
        .frontier_left (frontier_left),
        .maze_done     (maze_done),
        .last_of_step  (last_of_step),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

[tb/random_prim_maze_carver_unit_test.sv]
`timescale 1ns / 100ps

module random_prim_maze_carver_unit_test;

    import rpmc_pkg::*;

    // watchdog: cycles with no transaction on either channel
    localparam int STALL_LIMIT  = 60000;
    // quiet time before a register write or the end; covers clear and removal passes
    localparam int SETTLE       = 10000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic              action;
        logic [RAND_W-1:0] rand_a;
        logic [RAND_W-1:0] rand_b;
        logic              drain_first;
    } carve_req_t;

    typedef struct packed {
        logic [MAP_W-1:0]  row;
        logic [MAP_W-1:0]  col;
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  left;
        logic              done;
        logic              last;
    } carve_res_t;

    typedef struct packed {
        logic [SIDE_W-1:0] row;
        logic [SIDE_W-1:0] col;
        logic [ND_W-1:0]   ndirs;
        logic [DIRS_W-1:0] dirs;
    } front_entry_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = REG_WIDTH;
    logic [SIZE_W-1:0] cfg_data = '0;
    logic req_valid = 1'b0;
    logic req_stall;
    logic action = 1'b0;
    logic [RAND_W-1:0] random_first = '0;
    logic [RAND_W-1:0] random_second = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    logic [MAP_W-1:0] map_row;
    logic [MAP_W-1:0] map_col;
    logic [KIND_W-1:0] carve_kind;
    logic [CNT_W-1:0] frontier_left;
    logic maze_done;
    logic last_of_step;

    random_prim_maze_carver_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .action        (action),
        .random_first  (random_first),
        .random_second (random_second),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .map_row       (map_row),
        .map_col       (map_col),
        .carve_kind    (carve_kind),
        .frontier_left (frontier_left),
        .maze_done     (maze_done),
        .last_of_step  (last_of_step)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // shadow state of the maze carver
    // ---------------------------------------------------------------
    logic [SIZE_W-1:0] maze_width = SIZE_W'(8);
    logic [SIZE_W-1:0] maze_height = SIZE_W'(8);
    logic [1:0] cell_state [CELL_COUNT];
    front_entry_t frontier_q[$];
    carve_res_t carve_results[$];

    carve_req_t pending_steps[$];
    int mismatches = 0;
    int n_starts = 0;
    int n_grows = 0;
    int n_empty_grows = 0;
    int n_results = 0;
    int n_settings = 1;
    int idle_max = 17;
    int hold_requests = 0;

    function automatic int side_limit(input logic [SIZE_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (v > SIZE_W'(MAX_SIDE))
        begin
            return MAX_SIDE;
        end
        return int'(v);
    endfunction

    // row / column offsets by direction: north, south, east, west
    function automatic int dir_dr(input logic [1:0] d);
        case (d)
            DIR_N: return -1;
            DIR_S: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic int dir_dc(input logic [1:0] d);
        case (d)
            DIR_E: return 1;
            DIR_W: return -1;
            default: return 0;
        endcase
    endfunction

    function automatic carve_res_t make_result(input int r, input int c,
                                               input logic [KIND_W-1:0] k,
                                               input logic last);
        carve_res_t res;
        res.row  = MAP_W'(r);
        res.col  = MAP_W'(c);
        res.kind = k;
        res.left = CNT_W'(frontier_q.size());
        res.done = (frontier_q.size() == 0);
        res.last = last;
        return res;
    endfunction

    // add unvisited neighbours of a freshly carved cell, or extra discoverers
    task automatic grow_frontier(input int row, input int col);
        int w;
        int h;
        int nr;
        int nc;
        int idx;
        logic [1:0] d;
        front_entry_t e;
        w = side_limit(maze_width);
        h = side_limit(maze_height);
        for (int k = 0; k < 4; k++)
        begin
            d = 2'(k);
            nr = row + dir_dr(d);
            nc = col + dir_dc(d);
            if (nr < 0 || nc < 0 || nr >= h || nc >= w)
            begin
                continue;
            end
            idx = nr * MAX_SIDE + nc;
            if (cell_state[idx] == ST_UNVISITED)
            begin
                if (frontier_q.size() < CELL_COUNT)
                begin
                    e.row = SIDE_W'(nr);
                    e.col = SIDE_W'(nc);
                    e.ndirs = ND_W'(1);
                    e.dirs = '0;
                    e.dirs[1:0] = d;
                    frontier_q.push_back(e);
                    cell_state[idx] = ST_FRONTIER;
                end
            end
            else if (cell_state[idx] == ST_FRONTIER)
            begin
                for (int i = 0; i < frontier_q.size(); i++)
                begin
                    if (frontier_q[i].row == SIDE_W'(nr) && frontier_q[i].col == SIDE_W'(nc))
                    begin
                        if (frontier_q[i].ndirs < 4)
                        begin
                            frontier_q[i].dirs[2*frontier_q[i].ndirs +: 2] = d;
                            frontier_q[i].ndirs = frontier_q[i].ndirs + 1'b1;
                        end
                        break;
                    end
                end
            end
        end
    endtask

    // predict the results of one accepted transaction
    task automatic carve_predict(input carve_req_t t);
        int row;
        int col;
        int pick;
        int nd;
        int cr;
        int cc;
        logic [1:0] d;
        front_entry_t e;
        if (t.action == 1'b0)
        begin
            n_starts++;
            col = int'(t.rand_a % RAND_W'(side_limit(maze_width)));
            row = int'(t.rand_b % RAND_W'(side_limit(maze_height)));
            foreach (cell_state[i])
            begin
                cell_state[i] = ST_UNVISITED;
            end
            frontier_q.delete();
            cell_state[row * MAX_SIDE + col] = ST_CARVED;
            grow_frontier(row, col);
            carve_results.push_back(make_result(2 * row + 1, 2 * col + 1, KIND_CELL, 1'b1));
        end
        else if (frontier_q.size() == 0)
        begin
            n_empty_grows++;
            carve_results.push_back(make_result(0, 0, KIND_NONE, 1'b1));
        end
        else
        begin
            n_grows++;
            pick = int'(t.rand_a % RAND_W'(frontier_q.size()));
            e = frontier_q[pick];
            nd = (e.ndirs == 0) ? 1 : int'(e.ndirs);
            d = e.dirs[2 * int'(t.rand_b % RAND_W'(nd)) +: 2];
            cr = 2 * int'(e.row) + 1;
            cc = 2 * int'(e.col) + 1;
            cell_state[int'(e.row) * MAX_SIDE + int'(e.col)] = ST_CARVED;
            grow_frontier(int'(e.row), int'(e.col));
            frontier_q.delete(pick);
            // wall sits between the new cell and its discoverer
            carve_results.push_back(make_result(cr - dir_dr(d), cc - dir_dc(d), KIND_WALL, 1'b0));
            carve_results.push_back(make_result(cr, cc, KIND_CELL, 1'b1));
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // driver: offers queued transactions with random gaps
    // ---------------------------------------------------------------
    carve_req_t cur_req;
    logic offering = 1'b0;
    int gap_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (offering && !req_stall)
            begin
                carve_predict(cur_req);
                offering = 1'b0;
                gap_left = $urandom_range(0, idle_max);
            end
            if (!offering)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_steps.size() > 0 &&
                         !(pending_steps[0].drain_first && carve_results.size() != 0))
                begin
                    // a marked transaction waits until every result is back
                    cur_req = pending_steps.pop_front();
                    offering = 1'b1;
                    action <= cur_req.action;
                    random_first <= cur_req.rand_a;
                    random_second <= cur_req.rand_b;
                end
            end
            req_valid <= offering;
        end
    end

    // ---------------------------------------------------------------
    // monitor: random stall, compares each result with the oldest expectation
    // ---------------------------------------------------------------
    int stall_left = 0;
    int holds_served = 0;
    carve_res_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                n_results++;
                if (carve_results.size() == 0)
                begin
                    report_mismatch("unexpected result, kind", int'(carve_kind), -1);
                end
                else
                begin
                    want = carve_results.pop_front();
                    if (map_row !== want.row)
                        report_mismatch("map_row", int'(map_row), int'(want.row));
                    if (map_col !== want.col)
                        report_mismatch("map_col", int'(map_col), int'(want.col));
                    if (carve_kind !== want.kind)
                        report_mismatch("carve_kind", int'(carve_kind), int'(want.kind));
                    if (frontier_left !== want.left)
                        report_mismatch("frontier_left", int'(frontier_left), int'(want.left));
                    if (maze_done !== want.done)
                        report_mismatch("maze_done", int'(maze_done), int'(want.done));
                    if (last_of_step !== want.last)
                        report_mismatch("last_of_step", int'(last_of_step), int'(want.last));
                end
                stall_left = $urandom_range(0, idle_max);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            // long hold-off so the block backs up into its input
            if (holds_served < hold_requests)
            begin
                holds_served++;
                stall_left = HOLD_CYCLES;
            end
            rsp_stall <= (stall_left > 0);
        end
    end

    // ---------------------------------------------------------------
    // watchdog
    // ---------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    function automatic carve_req_t make_req(input logic act, input logic [RAND_W-1:0] a,
                                            input logic [RAND_W-1:0] b);
        carve_req_t t;
        t.action = act;
        t.rand_a = a;
        t.rand_b = b;
        t.drain_first = ($urandom_range(0, 99) == 0);
        return t;
    endfunction

    function automatic logic [RAND_W-1:0] rand_word();
        return RAND_W'($urandom);
    endfunction

    task automatic wait_idle();
        wait (pending_steps.size() == 0 && !offering && carve_results.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_sizes(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= REG_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        maze_width = w;
        maze_height = h;
        n_settings++;
    endtask

    // well-formed mazes with random content, some noise between them
    task automatic fill_phase(input int budget, input bit leftover_first);
        int added;
        int cells;
        int grows;
        added = 0;
        if (leftover_first)
        begin
            // keep carving the old frontier under the new sizes
            for (int i = 0; i < 6; i++)
            begin
                pending_steps.push_back(make_req(1'b1, rand_word(), rand_word()));
            end
            added += 6;
        end
        while (added < budget)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                grows = $urandom_range(1, 4);
                for (int i = 0; i < grows; i++)
                begin
                    pending_steps.push_back(make_req(1'($urandom), rand_word(), rand_word()));
                end
                added += grows;
            end
            else
            begin
                cells = side_limit(maze_width) * side_limit(maze_height);
                if (cells <= 60)
                    grows = cells - 1 + $urandom_range(0, 2);
                else
                    grows = $urandom_range(20, 60);
                pending_steps.push_back(make_req(1'b0, rand_word(), rand_word()));
                for (int i = 0; i < grows; i++)
                begin
                    pending_steps.push_back(make_req(1'b1, rand_word(), rand_word()));
                end
                added += grows + 1;
            end
        end
    endtask

    localparam logic [RAND_W-1:0] RMAX = {RAND_W{1'b1}};

    int phase_w[9] = '{1, 0, 64, 127, 2, 5, 1, 3, 7};
    int phase_h[9] = '{1, 0, 64, 3, 127, 1, 7, 6, 2};
    int budget;

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed part on the reset sizes: empty frontier, word extremes
        pending_steps.push_back(make_req(1'b1, RMAX, RMAX));
        pending_steps.push_back(make_req(1'b0, RMAX, '0));
        pending_steps.push_back(make_req(1'b1, '0, '0));
        pending_steps.push_back(make_req(1'b1, RMAX, RMAX));
        pending_steps.push_back(make_req(1'b1, '0, RMAX));
        pending_steps.push_back(make_req(1'b1, RMAX, '0));
        pending_steps.push_back(make_req(1'b0, '0, RMAX));
        for (int i = 0; i < 8; i++)
        begin
            pending_steps.push_back(make_req(1'b1, RMAX - RAND_W'(i), RAND_W'(i)));
        end
        pending_steps.push_back(make_req(1'b0, '0, '0));
        pending_steps.push_back(make_req(1'b0, RMAX, RMAX));
        idle_max = 0;
        wait_idle();

        for (int p = 0; p <= 9; p++)
        begin
            if (p == 9)
                write_sizes(SIZE_W'($urandom_range(1, 9)), SIZE_W'($urandom_range(1, 9)));
            else
                write_sizes(SIZE_W'(phase_w[p]), SIZE_W'(phase_h[p]));
            idle_max = (p % 4 == 3) ? 0 : 17;
            budget = (side_limit(maze_width) * side_limit(maze_height) > 60) ? 120 : 215;
            fill_phase(budget, (p % 2 == 1));
            if (p == 1)
            begin
                pending_steps[0].drain_first = 1'b1;
                wait (pending_steps.size() < budget / 2);
                hold_requests++;
            end
            wait_idle();
        end

        $display("carved %0d mazes with %0d grow steps and %0d empty-frontier grows",
                 n_starts, n_grows, n_empty_grows);
        $display("%0d results checked over %0d size settings, %0d mismatches",
                 n_results, n_settings, mismatches);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
